>>> src/rarsb_pkg.sv
// Shared constants, command codes and controller/datapath types for the range add/sum engine.
package rarsb_pkg;

    localparam int ELEMENTS   = 1024;
    localparam int BLOCK_SIZE = 32;
    localparam int NUM_BLOCKS = ELEMENTS / BLOCK_SIZE;
    localparam int IDX_W      = $clog2(ELEMENTS);
    localparam int OFF_W      = $clog2(BLOCK_SIZE);
    localparam int BLK_W      = IDX_W - OFF_W;
    localparam int CNT_W      = 11;
    localparam int DATA_W     = 64;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_SUM  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_PEND_FETCH,
        OP_LOAD,
        OP_ELEM_ADD,
        OP_ELEM_SUM,
        OP_BSUM_UPD,
        OP_BLK_ADD,
        OP_BLK_SUM
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] elem_addr;
        logic [BLK_W-1:0] blk_addr;
        logic             take;
        logic             emit;
        logic             emit_err;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_stat_t;

endpackage

>>> src/range_add_range_sum_blocks.sv
// Range add / range sum engine over 1024 signed 64-bit elements kept in blocks of 32. After
// reset the block runs a clearing pass (one element per cycle) before it takes the first
// item; configuration writes are taken at any time. A load passes through a pending fetch
// and a write state, a bad item goes straight to the response state and an unused command
// is dropped. A range add or query walks its first edge block, then the whole blocks in
// between, then the last edge block, one element or block per cycle through the memory
// read ports; each edge block opens with a pending fetch and, for an add, closes with a
// block-sum update. A result that waits on a full output register holds the next item
// back until it moves. Sums wrap modulo 2^64.
module range_add_range_sum_blocks (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // first_index[9:0], last_index[19:10], value[83:20], zero pad
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // total
    output logic         m_tuser,   // range_error
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [10:0]  cfg_data   // element_count
);
    import rarsb_pkg::*;

    dp_cmd_t  dpc;
    dp_stat_t stat;

    rarsb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .cmd         (s_tuser),
        .first_index (s_tdata[9:0]),
        .last_index  (s_tdata[19:10]),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .m_tready    (m_tready),
        .stat        (stat),
        .dpc         (dpc)
    );

    rarsb_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .dpc      (dpc),
        .stat     (stat),
        .value    (s_tdata[83:20]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> src/rarsb_dp.sv
// Datapath: element and block memories, two-stage read/update pipe, accumulator, output register.
module rarsb_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rarsb_pkg::dp_cmd_t        dpc,
    output rarsb_pkg::dp_stat_t       stat,
    input  logic [rarsb_pkg::DATA_W-1:0] value,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [rarsb_pkg::DATA_W-1:0] m_tdata,  // total
    output logic                      m_tuser      // range_error
);
    import rarsb_pkg::*;

    logic [DATA_W-1:0] elem_mem [ELEMENTS];
    logic [DATA_W-1:0] bsum_mem [NUM_BLOCKS];
    logic [DATA_W-1:0] pend_mem [NUM_BLOCKS];

    logic [DATA_W-1:0] elem_rd_reg, bsum_rd_reg, pend_rd_reg;
    op_t               op_reg;
    logic [IDX_W-1:0]  eaddr_reg;
    logic [BLK_W-1:0]  baddr_reg;

    logic [DATA_W-1:0] v_reg, pend_reg, delta_reg, acc_reg;
    logic [DATA_W-1:0] pend_next, delta_next, acc_next;
    logic              out_valid_reg, out_err_reg;
    logic [DATA_W-1:0] out_total_reg;

    logic              elem_we, bsum_we, pend_we;
    logic [DATA_W-1:0] elem_wd, bsum_wd, pend_wd, newv;
    logic              clr_blk;

    assign newv    = v_reg - pend_reg;
    assign clr_blk = ((IDX_W+1)'(eaddr_reg) < (IDX_W+1)'(NUM_BLOCKS));

    always_comb
    begin
        elem_we    = 1'b0;
        bsum_we    = 1'b0;
        pend_we    = 1'b0;
        elem_wd    = '0;
        bsum_wd    = '0;
        pend_wd    = '0;
        pend_next  = pend_reg;
        delta_next = delta_reg;
        acc_next   = acc_reg;
        case (op_reg)
            OP_CLEAR:
            begin
                elem_we = 1'b1;
                bsum_we = clr_blk;
                pend_we = clr_blk;
            end
            OP_PEND_FETCH: pend_next = pend_rd_reg;
            OP_LOAD:
            begin
                elem_we = 1'b1;
                elem_wd = newv;
                bsum_we = 1'b1;
                bsum_wd = bsum_rd_reg + newv - elem_rd_reg;
            end
            OP_ELEM_ADD:
            begin
                elem_we    = 1'b1;
                elem_wd    = elem_rd_reg + v_reg;
                delta_next = delta_reg + v_reg;
            end
            OP_ELEM_SUM: acc_next = acc_reg + elem_rd_reg + pend_reg;
            OP_BSUM_UPD:
            begin
                bsum_we    = 1'b1;
                bsum_wd    = bsum_rd_reg + delta_reg;
                delta_next = '0;
            end
            OP_BLK_ADD:
            begin
                pend_we = 1'b1;
                pend_wd = pend_rd_reg + v_reg;
            end
            OP_BLK_SUM: acc_next = acc_reg + bsum_rd_reg + (pend_rd_reg << OFF_W);
            default: ;
        endcase
        // start a fresh item
        if (dpc.take)
        begin
            acc_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_rd_reg <= elem_mem[dpc.elem_addr];
        if (elem_we)
        begin
            elem_mem[eaddr_reg] <= elem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        bsum_rd_reg <= bsum_mem[dpc.blk_addr];
        if (bsum_we)
        begin
            bsum_mem[baddr_reg] <= bsum_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_rd_reg <= pend_mem[dpc.blk_addr];
        if (pend_we)
        begin
            pend_mem[baddr_reg] <= pend_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        eaddr_reg <= dpc.elem_addr;
        baddr_reg <= dpc.blk_addr;
        pend_reg  <= pend_next;
        acc_reg   <= acc_next;
        if (dpc.take)
        begin
            v_reg <= value;
        end
        if (dpc.emit)
        begin
            out_total_reg <= dpc.emit_err ? '0 : acc_reg;
            out_err_reg   <= dpc.emit_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_NONE;
            delta_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_reg    <= dpc.op;
            delta_reg <= delta_next;
            if (dpc.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_full = out_valid_reg;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_total_reg;
    assign m_tuser       = out_err_reg;

endmodule

>>> src/rarsb_ctrl.sv
// Controller: range check, clearing pass and the per-item walk over edge and whole blocks.
module rarsb_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [1:0]                   cmd,
    input  logic [rarsb_pkg::IDX_W-1:0]  first_index,
    input  logic [rarsb_pkg::IDX_W-1:0]  last_index,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rarsb_pkg::CNT_W-1:0]  cfg_data,
    input  logic                         m_tready,
    input  rarsb_pkg::dp_stat_t          stat,
    output rarsb_pkg::dp_cmd_t           dpc
);
    import rarsb_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LD_PF, S_LOAD, S_A_PF, S_A_RUN, S_A_UPD,
        S_MID, S_B_PF, S_B_RUN, S_B_UPD, S_QWAIT, S_RESP
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    cmd_t             cmd_reg;
    logic [IDX_W-1:0] l_reg, r_reg;
    logic             err_reg, err_next;
    logic [CNT_W-1:0] count_reg, live_n;

    logic [BLK_W-1:0] p, q;
    logic [IDX_W-1:0] end_a;
    logic             is_add, take, bad;
    cmd_t             cmd_in;
    state_t           after_a;

    assign cmd_in = cmd_t'(cmd);
    assign live_n = (count_reg > CNT_W'(ELEMENTS)) ? CNT_W'(ELEMENTS) : count_reg;
    assign p      = l_reg[IDX_W-1:OFF_W];
    assign q      = r_reg[IDX_W-1:OFF_W];
    assign end_a  = (p == q) ? r_reg : {p, {OFF_W{1'b1}}};
    assign is_add = (cmd_reg == CMD_ADD);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign take      = s_tvalid && s_tready;

    always_comb
    begin
        if (cmd_in == CMD_LOAD)
        begin
            bad = (CNT_W'(first_index) >= live_n);
        end
        else
        begin
            bad = (first_index > last_index) || (CNT_W'(last_index) >= live_n);
        end
    end

    always_comb
    begin
        if (p == q)
        begin
            after_a = is_add ? S_IDLE : S_QWAIT;
        end
        else if (({1'b0, p} + 1'b1) < {1'b0, q})
        begin
            after_a = S_MID;
        end
        else
        begin
            after_a = S_B_PF;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        blk_next      = blk_reg;
        err_next      = err_reg;
        dpc.op        = OP_NONE;
        dpc.elem_addr = idx_reg;
        dpc.blk_addr  = p;
        dpc.take      = take;
        dpc.emit      = 1'b0;
        dpc.emit_err  = err_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                dpc.op       = OP_CLEAR;
                dpc.blk_addr = idx_reg[BLK_W-1:0];
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == {IDX_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    err_next = bad;
                    if (cmd_in == CMD_NOP)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (bad)
                    begin
                        state_next = S_RESP;
                    end
                    else if (cmd_in == CMD_LOAD)
                    begin
                        state_next = S_LD_PF;
                    end
                    else
                    begin
                        state_next = S_A_PF;
                    end
                end
            end
            S_LD_PF:
            begin
                dpc.op     = OP_PEND_FETCH;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                dpc.op        = OP_LOAD;
                dpc.elem_addr = l_reg;
                state_next    = S_IDLE;
            end
            S_A_PF:
            begin
                dpc.op     = OP_PEND_FETCH;
                idx_next   = l_reg;
                state_next = S_A_RUN;
            end
            S_A_RUN:
            begin
                dpc.op   = is_add ? OP_ELEM_ADD : OP_ELEM_SUM;
                idx_next = idx_reg + 1'b1;
                blk_next = p + 1'b1;
                if (idx_reg == end_a)
                begin
                    state_next = is_add ? S_A_UPD : after_a;
                end
            end
            S_A_UPD:
            begin
                dpc.op     = OP_BSUM_UPD;
                blk_next   = p + 1'b1;
                state_next = after_a;
            end
            S_MID:
            begin
                dpc.op       = is_add ? OP_BLK_ADD : OP_BLK_SUM;
                dpc.blk_addr = blk_reg;
                blk_next     = blk_reg + 1'b1;
                if ((blk_reg + 1'b1) == q)
                begin
                    state_next = S_B_PF;
                end
            end
            S_B_PF:
            begin
                dpc.op       = OP_PEND_FETCH;
                dpc.blk_addr = q;
                idx_next     = {q, {OFF_W{1'b0}}};
                state_next   = S_B_RUN;
            end
            S_B_RUN:
            begin
                dpc.op       = is_add ? OP_ELEM_ADD : OP_ELEM_SUM;
                dpc.blk_addr = q;
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == r_reg)
                begin
                    state_next = is_add ? S_B_UPD : S_QWAIT;
                end
            end
            S_B_UPD:
            begin
                dpc.op       = OP_BSUM_UPD;
                dpc.blk_addr = q;
                state_next   = S_IDLE;
            end
            S_QWAIT: state_next = S_RESP;
            S_RESP:
            begin
                if (!stat.out_full || m_tready)
                begin
                    dpc.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            blk_reg   <= '0;
            err_reg   <= 1'b0;
            cmd_reg   <= CMD_NOP;
            l_reg     <= '0;
            r_reg     <= '0;
            count_reg <= CNT_W'(ELEMENTS);
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            blk_reg   <= blk_next;
            err_reg   <= err_next;
            if (take)
            begin
                cmd_reg <= cmd_in;
                l_reg   <= first_index;
                r_reg   <= last_index;
            end
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

endmodule
